### rtl/core/sxlp_pkg.sv
// shared types and constants for the sysex loader parser
// no dependencies; imported by every module of the block
package sxlp_pkg;

	// result kinds
	localparam logic [1:0] KIND_FORWARD = 2'd0;
	localparam logic [1:0] KIND_WRITE   = 2'd1;
	localparam logic [1:0] KIND_BLOCK   = 2'd2;

	// escape sequence and command codes
	localparam logic [7:0] ESC_START = 8'hF0;
	localparam logic [7:0] ESC_ID    = 8'h7D;
	localparam logic [7:0] ESC_CHAR1 = 8'h47;
	localparam logic [7:0] ESC_CHAR2 = 8'h42;
	localparam logic [7:0] CMD_FILL  = 8'h00;
	localparam logic [7:0] CMD_BLOCK = 8'h01;

	// parser phase, one-hot
	typedef enum logic [7:0] {
		PH_IDLE   = 8'b0000_0001,
		PH_CMD    = 8'b0000_0010,
		PH_ADDR_A = 8'b0000_0100,
		PH_ADDR_B = 8'b0000_1000,
		PH_DATA_A = 8'b0001_0000,
		PH_DATA_B = 8'b0010_0000,
		PH_BLK_A  = 8'b0100_0000,
		PH_BLK_B  = 8'b1000_0000
	} phase_t;

	// one parser result, passed to the output register
	typedef struct packed {
		logic       emit;
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [7:0] buffer_address;
	} res_t;

endpackage

### rtl/core/sxlp_parse.sv
// parser state and per-byte decode of the sysex loader parser
// depends on sxlp_pkg
module sxlp_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         byte_in,
	output sxlp_pkg::res_t     res
);
	import sxlp_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] recent_q [3];
	logic [7:0] wpos_q, wpos_d;
	logic [3:0] nib_q, nib_d;
	logic       shift_hist;
	logic [7:0] joined;

	// value from stored high nibble and whole second byte
	assign joined = {nib_q, 4'h0} | byte_in;

	// next state and result for the byte in the input register
	always_comb begin
		phase_d    = phase_q;
		wpos_d     = wpos_q;
		nib_d      = nib_q;
		shift_hist = 1'b0;
		res        = '0;
		case (phase_q)
			PH_IDLE: begin
				shift_hist         = 1'b1;
				res.emit           = 1'b1;
				res.kind           = KIND_FORWARD;
				res.data_byte      = byte_in;
				if (recent_q[0] == ESC_START && recent_q[1] == ESC_ID &&
				    recent_q[2] == ESC_CHAR1 && byte_in == ESC_CHAR2)
					phase_d = PH_CMD;
			end
			PH_CMD: begin
				if (byte_in == CMD_FILL)
					phase_d = PH_ADDR_A;
				else if (byte_in == CMD_BLOCK)
					phase_d = PH_BLK_A;
				else
					phase_d = PH_IDLE;
			end
			PH_ADDR_A: begin
				nib_d   = byte_in[3:0];
				phase_d = PH_ADDR_B;
			end
			PH_ADDR_B: begin
				wpos_d  = joined;
				phase_d = PH_DATA_A;
			end
			PH_DATA_A: begin
				if (byte_in[7]) begin
					phase_d = PH_IDLE;
				end else begin
					nib_d   = byte_in[3:0];
					phase_d = PH_DATA_B;
				end
			end
			PH_DATA_B: begin
				if (byte_in[7]) begin
					phase_d = PH_IDLE;
				end else begin
					res.emit           = 1'b1;
					res.kind           = KIND_WRITE;
					res.data_byte      = joined;
					res.buffer_address = wpos_q;
					wpos_d             = wpos_q + 8'd1;
					phase_d            = PH_DATA_A;
				end
			end
			PH_BLK_A: begin
				nib_d   = byte_in[3:0];
				phase_d = PH_BLK_B;
			end
			PH_BLK_B: begin
				res.emit      = 1'b1;
				res.kind      = KIND_BLOCK;
				res.data_byte = joined;
				phase_d       = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// state registers, updated when the byte is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			wpos_q      <= '0;
			nib_q       <= '0;
			recent_q[0] <= '0;
			recent_q[1] <= '0;
			recent_q[2] <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			wpos_q  <= wpos_d;
			nib_q   <= nib_d;
			if (shift_hist) begin
				recent_q[0] <= recent_q[1];
				recent_q[1] <= recent_q[2];
				recent_q[2] <= byte_in;
			end
		end
	end

endmodule

### rtl/core/sxlp_out_reg.sv
// output register holding one result transaction until taken
// depends on sxlp_pkg
module sxlp_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  sxlp_pkg::res_t     res,
	input  logic               out_ready,
	output logic               out_valid,
	output logic               can_load,
	output logic [1:0]         kind,
	output logic [7:0]         data_byte,
	output logic [7:0]         buffer_address
);
	import sxlp_pkg::*;

	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] data_q;
	logic [7:0] addr_q;

	// free when empty or draining this cycle
	assign can_load = !valid_q || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (can_load)
			valid_q <= load && res.emit;
	end

	// payload
	always_ff @(posedge clk) begin
		if (can_load && load && res.emit) begin
			kind_q <= res.kind;
			data_q <= res.data_byte;
			addr_q <= res.buffer_address;
		end
	end

	assign out_valid      = valid_q;
	assign kind           = kind_q;
	assign data_byte      = data_q;
	assign buffer_address = addr_q;

endmodule

### rtl/core/sysex_loader_parser.sv
// MIDI byte parser with a sysex loader escape
// Channels: input transaction carries midi_byte (in_valid/in_ready); output
// transaction carries kind, data_byte, buffer_address (out_valid/out_ready).
// Every accepted byte is forwarded (kind 0) while idle. After F0 7D 'G' 'B'
// a command byte follows: command 0 takes a two-byte start address and then
// byte pairs, each giving a buffer write (kind 1) at an incrementing address;
// a data byte with bit 7 set ends the run. Command 1 takes a two-byte block
// number and gives one program request (kind 2). Consumed bytes give no output.
// Path: an accepted byte waits in the input register and is decoded from there
// into the output register, where its result is then valid.
// Throughput: one byte per cycle unless stalled, set by the input register and
// the one output register, which load on the edge the previous result leaves.
// Stall: while out_ready is low and a result waits, the byte in the input
// register holds if it produces a result, and in_ready drops; bytes that
// produce nothing still pass.
// Reset (arst_n low): idle phase, history, write address and nibble cleared,
// both registers empty.
// depends on sxlp_pkg, sxlp_parse, sxlp_out_reg
module sysex_loader_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] midi_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] buffer_address
);
	import sxlp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       can_load;
	logic       advance;
	res_t       res;

	// byte in the input register leaves when its result has room
	assign advance  = valid_s1 && (!res.emit || can_load);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= midi_byte;
	end

	// decode and parser state
	sxlp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (advance),
		.byte_in (byte_s1),
		.res     (res)
	);

	// result register
	sxlp_out_reg u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (advance),
		.res            (res),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.can_load       (can_load),
		.kind           (kind),
		.data_byte      (data_byte),
		.buffer_address (buffer_address)
	);

	// address field only set on buffer writes
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_WRITE |-> buffer_address == 8'd0)
		else $error("buffer_address nonzero outside a buffer write");

	// input stalls only with a byte held in the input register
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("in_ready low with empty input register");

	// a new result comes only from a byte held in the input register
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result appeared without a held byte");

endmodule

### dv/sysex_loader_parser_tb.sv
// testbench for sysex_loader_parser: drives MIDI byte transactions, models the parser
// in the bench and checks every output transaction in order
// depends on sxlp_pkg and the sysex_loader_parser rtl
module sysex_loader_parser_tb;
	import sxlp_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int HOLD_AT      = 700;
	localparam int DRAIN_AT     = 1200;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 10;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [7:0] buffer_address;
	} parser_out_t;

	typedef struct {
		logic [7:0]  midi_byte;
		bit          typed;
		parser_out_t want;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] midi_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [7:0] buffer_address;

	sysex_loader_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.midi_byte      (midi_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.data_byte      (data_byte),
		.buffer_address (buffer_address)
	);

	always #HALF_PERIOD clk = ~clk;

	// parser model state
	phase_t     model_phase;
	logic [7:0] model_hist [3];
	logic [7:0] model_wpos;
	logic [3:0] model_nibble;

	parser_out_t pending_results [$];
	stim_row_t   directed_rows [$];

	int  errors = 0;
	int  items_sent = 0;
	int  burst_left = 0;
	int  cycles = 0;
	int  n_forward = 0;
	int  n_write = 0;
	int  n_block = 0;
	bit  hold_req = 1'b0;
	int  hold_left = 0;
	int  stall_mode = 0;
	int  mode_left = 0;
	int  stall_tick = 0;

	// advance the parser model by one byte, returns 1 when a result is produced
	function automatic bit parse_byte(input logic [7:0] b, output parser_out_t r);
		bit hit;
		r = '0;
		case (model_phase)
			PH_IDLE: begin
				hit = model_hist[0] == ESC_START && model_hist[1] == ESC_ID &&
					model_hist[2] == ESC_CHAR1 && b == ESC_CHAR2;
				model_hist[0] = model_hist[1];
				model_hist[1] = model_hist[2];
				model_hist[2] = b;
				if (hit) model_phase = PH_CMD;
				r = {KIND_FORWARD, b, 8'h00};
				return 1'b1;
			end
			PH_CMD: begin
				if (b == CMD_FILL) model_phase = PH_ADDR_A;
				else if (b == CMD_BLOCK) model_phase = PH_BLK_A;
				else model_phase = PH_IDLE;
			end
			PH_ADDR_A: begin
				model_nibble = b[3:0];
				model_phase = PH_ADDR_B;
			end
			PH_ADDR_B: begin
				model_wpos = {model_nibble, 4'h0} | b;
				model_phase = PH_DATA_A;
			end
			PH_DATA_A: begin
				if (b[7]) begin
					model_phase = PH_IDLE;
				end else begin
					model_nibble = b[3:0];
					model_phase = PH_DATA_B;
				end
			end
			PH_DATA_B: begin
				if (b[7]) begin
					model_phase = PH_IDLE;
				end else begin
					r = {KIND_WRITE, {model_nibble, 4'h0} | b, model_wpos};
					model_wpos = model_wpos + 8'd1;
					model_phase = PH_DATA_A;
					return 1'b1;
				end
			end
			PH_BLK_A: begin
				model_nibble = b[3:0];
				model_phase = PH_BLK_B;
			end
			PH_BLK_B: begin
				r = {KIND_BLOCK, {model_nibble, 4'h0} | b, 8'h00};
				model_phase = PH_IDLE;
				return 1'b1;
			end
			default: model_phase = PH_IDLE;
		endcase
		return 1'b0;
	endfunction

	task automatic note_failure(input string msg);
		errors++;
		if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
	endtask

	task automatic add_row(input logic [7:0] b, input bit typed, input logic [1:0] k,
			input logic [7:0] d, input logic [7:0] a);
		stim_row_t row;
		row.midi_byte = b;
		row.typed = typed;
		row.want = {k, d, a};
		directed_rows.push_back(row);
	endtask

	// offer one byte transaction in bursts with random gaps, then record its result
	task automatic send_byte(input logic [7:0] b, input bit typed, input parser_out_t want);
		int gap;
		parser_out_t r;
		bit has_result;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 60);
		end
		in_valid <= 1'b1;
		midi_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		items_sent++;
		has_result = parse_byte(b, r);
		if (typed) begin
			r = want;
			has_result = 1'b1;
		end
		if (has_result) pending_results.push_back(r);
	endtask

	// receiver stall pattern, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(32, 256);
			end
			mode_left--;
			stall_tick++;
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= (stall_tick % 4) != 3;
				default: out_ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// output transaction check against the oldest pending result
	always @(posedge clk) begin : out_monitor
		parser_out_t got;
		parser_out_t want;
		if (out_valid && out_ready) begin
			got = {kind, data_byte, buffer_address};
			case (got.kind)
				KIND_FORWARD: n_forward++;
				KIND_WRITE:   n_write++;
				default:      n_block++;
			endcase
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result kind=%0d data=%02h addr=%02h",
					got.kind, got.data_byte, got.buffer_address));
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
						got.buffer_address !== want.buffer_address)
					note_failure($sformatf(
						"expected kind=%0d data=%02h addr=%02h, got kind=%0d data=%02h addr=%02h",
						want.kind, want.data_byte, want.buffer_address,
						got.kind, got.data_byte, got.buffer_address));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		logic [7:0] seq [$];
		int pick;
		int pairs;
		int end_mode;
		int directed_count;
		bit hold_done;
		bit drain_done;

		hold_done = 1'b0;
		drain_done = 1'b0;
		model_phase = PH_IDLE;
		model_hist[0] = 8'h00;
		model_hist[1] = 8'h00;
		model_hist[2] = 8'h00;
		model_wpos = 8'h00;
		model_nibble = 4'h0;

		// byte extremes while idle
		add_row(8'h00, 1, KIND_FORWARD, 8'h00, 8'h00);
		add_row(8'hFF, 1, KIND_FORWARD, 8'hFF, 8'h00);
		// escape, fill from ff: second address byte ors in bits 4 to 6, then wrap to 00
		add_row(ESC_START, 1, KIND_FORWARD, ESC_START, 8'h00);
		add_row(ESC_ID,    1, KIND_FORWARD, ESC_ID,    8'h00);
		add_row(ESC_CHAR1, 1, KIND_FORWARD, ESC_CHAR1, 8'h00);
		add_row(ESC_CHAR2, 1, KIND_FORWARD, ESC_CHAR2, 8'h00);
		add_row(CMD_FILL, 0, KIND_FORWARD, 8'h00, 8'h00);
		add_row(8'h1F, 0, KIND_FORWARD, 8'h00, 8'h00);
		add_row(8'h7F, 0, KIND_FORWARD, 8'h00, 8'h00);
		add_row(8'h05, 0, KIND_FORWARD, 8'h00, 8'h00);
		add_row(8'h3A, 0, KIND_FORWARD, 8'h00, 8'h00);
		add_row(8'h0A, 0, KIND_FORWARD, 8'h00, 8'h00);
		add_row(8'h0B, 1, KIND_WRITE, 8'hAB, 8'h00);
		// end of run by a byte with bit 7 set
		add_row(8'h80, 0, KIND_FORWARD, 8'h00, 8'h00);
		// escape again, history still primed; block number with bit 7 in the first byte
		add_row(ESC_START, 1, KIND_FORWARD, ESC_START, 8'h00);
		add_row(ESC_ID,    1, KIND_FORWARD, ESC_ID,    8'h00);
		add_row(ESC_CHAR1, 1, KIND_FORWARD, ESC_CHAR1, 8'h00);
		add_row(ESC_CHAR2, 1, KIND_FORWARD, ESC_CHAR2, 8'h00);
		add_row(CMD_BLOCK, 0, KIND_FORWARD, 8'h00, 8'h00);
		add_row(8'h93, 0, KIND_FORWARD, 8'h00, 8'h00);
		add_row(8'h04, 1, KIND_BLOCK, 8'h34, 8'h00);
		// unknown command drops back to idle; history holds 7d 'G' 'B'
		add_row(ESC_START, 1, KIND_FORWARD, ESC_START, 8'h00);
		add_row(ESC_ID,    1, KIND_FORWARD, ESC_ID,    8'h00);
		add_row(ESC_CHAR1, 1, KIND_FORWARD, ESC_CHAR1, 8'h00);
		add_row(ESC_CHAR2, 1, KIND_FORWARD, ESC_CHAR2, 8'h00);
		add_row(8'h02, 0, KIND_FORWARD, 8'h00, 8'h00);
		add_row(ESC_CHAR2, 1, KIND_FORWARD, ESC_CHAR2, 8'h00);
		directed_count = directed_rows.size();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].midi_byte, directed_rows[i].typed, directed_rows[i].want);

		// random sequences, mostly well-formed loader commands with random content
		while (items_sent < directed_count + RANDOM_ITEMS) begin
			seq.delete();
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 20) begin
				// broken escape prefix
				seq.push_back(ESC_START);
				seq.push_back(ESC_ID);
				if ($urandom_range(0, 1)) seq.push_back(ESC_CHAR1);
				seq.push_back(8'($urandom_range(0, 255)));
			end else begin
				seq.push_back(ESC_START);
				seq.push_back(ESC_ID);
				seq.push_back(ESC_CHAR1);
				seq.push_back(ESC_CHAR2);
				if (pick < 65) begin
					seq.push_back(CMD_FILL);
					seq.push_back(8'($urandom_range(0, 255)));
					seq.push_back(8'($urandom_range(0, 255)));
					pairs = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 300) :
						$urandom_range(0, 12);
					repeat (pairs) begin
						seq.push_back(8'($urandom_range(0, 127)));
						seq.push_back(8'($urandom_range(0, 127)));
					end
					end_mode = $urandom_range(0, 9);
					if (end_mode < 5) begin
						seq.push_back(8'($urandom_range(128, 255)));
					end else if (end_mode < 9) begin
						// terminator in the second position drops the half pair
						seq.push_back(8'($urandom_range(0, 127)));
						seq.push_back(8'($urandom_range(128, 255)));
					end
				end else if (pick < 85) begin
					seq.push_back(CMD_BLOCK);
					seq.push_back(8'($urandom_range(0, 255)));
					seq.push_back(8'($urandom_range(0, 255)));
				end else begin
					seq.push_back(8'($urandom_range(2, 255)));
					repeat ($urandom_range(0, 3)) seq.push_back(8'($urandom_range(0, 255)));
				end
			end
			foreach (seq[i]) send_byte(seq[i], 1'b0, '0);

			// long receiver hold-off while the sender keeps offering
			if (!hold_done && items_sent >= HOLD_AT) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			// sender pause until all pending results are out
			if (!drain_done && items_sent >= DRAIN_AT) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() > 0) @(posedge clk);
				burst_left = $urandom_range(1, 60);
				drain_done = 1'b1;
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() > 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d byte transactions (%0d directed) over %0d cycles",
			items_sent, directed_count, cycles);
		$display("checked %0d forwards, %0d buffer writes, %0d block requests, %0d mismatches",
			n_forward, n_write, n_block, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
rtl/core/sxlp_pkg.sv
rtl/core/sxlp_parse.sv
rtl/core/sxlp_out_reg.sv
rtl/core/sysex_loader_parser.sv
dv/sysex_loader_parser_tb.sv
